// ===== design/gl1sd_pkg.sv =====
// Shared constants for the grouped L1-squared distance block.
`timescale 1ns / 1ps
`default_nettype none

package gl1sd_pkg;

    // Coordinates per group in one transfer.
    localparam int GROUP_SIZE = 4;

    // Entries in the queue between the arithmetic front and the accumulator.
    // It must cover the front latency plus the pop turnaround for full rate.
    localparam int QUEUE_DEPTH = 8;

endpackage

`default_nettype wire

// ===== design/gl1sd_front.sv =====
// Front pipeline: group L1 distance, square and saturation, with queue credits.
`timescale 1ns / 1ps
`default_nettype none

module gl1sd_front
    import gl1sd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int ACC_BITS   = 48
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [COORD_BITS-1:0] i_first  [GROUP_SIZE],
    input  wire logic signed [COORD_BITS-1:0] i_second [GROUP_SIZE],
    input  wire logic        [ACC_BITS-1:0]   i_bound,
    input  wire logic                         i_last,
    input  wire logic                         i_pop,
    output logic                              o_push,
    output logic             [ACC_BITS-1:0]   o_sq,
    output logic             [ACC_BITS-1:0]   o_bound,
    output logic                              o_last
);

    localparam int MAG_BITS = COORD_BITS + 1;
    localparam int SUM_BITS = MAG_BITS + 2;
    localparam int MUL_BITS = (SUM_BITS < 32) ? SUM_BITS : 32;
    localparam int PRD_BITS = 2 * MUL_BITS;
    localparam int CMP_BITS = (PRD_BITS > ACC_BITS) ? PRD_BITS : ACC_BITS;
    localparam int CRD_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [CRD_BITS-1:0] r_credit;
    logic [CRD_BITS-1:0] n_credit;
    logic                accept;

    logic                r_s1_valid;
    logic [SUM_BITS-1:0] r_s1_sum;
    logic [ACC_BITS-1:0] r_s1_bound;
    logic                r_s1_last;
    logic [SUM_BITS-1:0] n_s1_sum;

    logic                r_s2_valid;
    logic [PRD_BITS-1:0] r_s2_prod;
    logic                r_s2_big;
    logic [ACC_BITS-1:0] r_s2_bound;
    logic                r_s2_last;

    logic [CMP_BITS-1:0] prod_ext;
    logic                prod_over;

    // One credit per free queue slot; an item in the pipeline holds one.
    assign o_ready = (r_credit != '0);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_credit = r_credit;
        if (accept) begin
            n_credit = n_credit - CRD_BITS'(1);
        end
        if (i_pop) begin
            n_credit = n_credit + CRD_BITS'(1);
        end
    end

    always_comb begin
        logic signed [MAG_BITS-1:0] diff;
        logic        [MAG_BITS-1:0] mag;
        n_s1_sum = '0;
        for (int i = 0; i < GROUP_SIZE; i++) begin
            diff = MAG_BITS'(i_first[i]) - MAG_BITS'(i_second[i]);
            mag  = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
            n_s1_sum = n_s1_sum + SUM_BITS'(mag);
        end
    end

    assign prod_ext  = CMP_BITS'(r_s2_prod);
    assign prod_over = (prod_ext >> ACC_BITS) != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit   <= CRD_BITS'(QUEUE_DEPTH);
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            o_push     <= 1'b0;
        end else begin
            r_credit   <= n_credit;
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            o_push     <= r_s2_valid;
        end
        r_s1_sum   <= n_s1_sum;
        r_s1_bound <= i_bound;
        r_s1_last  <= i_last;

        r_s2_prod  <= PRD_BITS'(r_s1_sum[MUL_BITS-1:0]) * PRD_BITS'(r_s1_sum[MUL_BITS-1:0]);
        r_s2_big   <= (r_s1_sum >> 32) != '0;
        r_s2_bound <= r_s1_bound;
        r_s2_last  <= r_s1_last;

        o_sq       <= (r_s2_big || prod_over) ? '1 : prod_ext[ACC_BITS-1:0];
        o_bound    <= r_s2_bound;
        o_last     <= r_s2_last;
    end

endmodule

`default_nettype wire

// ===== design/gl1sd_queue.sv =====
// Small register queue between the front pipeline and the accumulator.
`timescale 1ns / 1ps
`default_nettype none

module gl1sd_queue
    import gl1sd_pkg::*;
#(
    parameter int WIDTH = 97
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_rdata
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    // Overflow cannot happen: the front only admits items it holds credit for.
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push) begin
            n_count = n_count + CNT_BITS'(1);
        end
        if (i_pop) begin
            n_count = n_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_BITS'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/gl1sd_back.sv =====
// Back end: saturating accumulation, early-exit test, skipping and result register.
`timescale 1ns / 1ps
`default_nettype none

module gl1sd_back #(
    parameter int ACC_BITS = 48
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  wire logic [ACC_BITS-1:0] i_sq,
    input  wire logic [ACC_BITS-1:0] i_bound,
    input  wire logic                i_last,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic      [ACC_BITS-1:0] o_distance,
    output logic                     o_over_bound
);

    logic [ACC_BITS-1:0] r_sum;
    logic                r_skipping;
    logic [ACC_BITS:0]   raw_sum;
    logic [ACC_BITS-1:0] total;
    logic                over;
    logic                emit;

    assign o_pop   = !i_empty && (!o_valid || i_ready);
    assign raw_sum = {1'b0, r_sum} + {1'b0, i_sq};
    assign total   = raw_sum[ACC_BITS] ? '1 : raw_sum[ACC_BITS-1:0];
    assign over    = total > i_bound;
    assign emit    = !r_skipping && (over || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_skipping <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                if (r_skipping) begin
                    r_sum      <= '0;
                    r_skipping <= !i_last;
                end else if (over) begin
                    r_sum      <= '0;
                    r_skipping <= !i_last;
                end else if (i_last) begin
                    r_sum <= '0;
                end else begin
                    r_sum <= total;
                end
            end
            if (o_pop && emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
        if (o_pop && emit) begin
            o_distance   <= total;
            o_over_bound <= over;
        end
    end

endmodule

`default_nettype wire

// ===== design/grouped_l1_squared_distance.sv =====
// Top level of the grouped L1-squared distance block with early exit.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one group of four coordinate pairs per transfer and
// accumulates, per point pair, the square of each group's L1 distance into a
// saturating sum. A result is sent either when the sum strictly exceeds the
// bound carried by the group, with the over-bound flag in tuser set, or with
// the group marked by tlast. After an early exit the remaining groups of that
// pair, up to and including the one with tlast, give no result. A bound of all
// ones never triggers the exit. One group is taken in every cycle while the
// front holds queue credit; a result passes through the front's L1-sum, square
// and saturation registers and the queue into the back end's result register,
// where it is held while the output is stalled. The rate is held by the front
// pipeline (L1 sum, square, saturation) running one group per stage and by
// the accumulate-and-compare loop in the back end, whose add and compare are
// combinational; an eight-entry queue between them absorbs output stalls, and
// the input accepts whenever the front holds a free queue slot in credit.

module grouped_l1_squared_distance
    import gl1sd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int ACC_BITS   = 48
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // From bit 0: first_x0..first_x3, second_x0..second_x3, bound, zero fill.
    input  wire logic [((2 * GROUP_SIZE * COORD_BITS + ACC_BITS + 7) / 8) * 8 - 1:0]
                                         i_s_axis_tdata,
    // last_group.
    input  wire logic                    i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // From bit 0: distance, zero fill.
    output logic [((ACC_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // over_bound.
    output logic                         o_m_axis_tuser
);

    localparam int IN_FIELD_BITS = 2 * GROUP_SIZE * COORD_BITS + ACC_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((ACC_BITS + 7) / 8) * 8;
    localparam int BOUND_LSB     = 2 * GROUP_SIZE * COORD_BITS;
    localparam int ENTRY_BITS    = 2 * ACC_BITS + 1;

    logic signed [COORD_BITS-1:0] first  [GROUP_SIZE];
    logic signed [COORD_BITS-1:0] second [GROUP_SIZE];
    logic        [ACC_BITS-1:0]   bound;

    // Front-to-queue transfer.
    logic                  push;
    logic [ACC_BITS-1:0]   push_sq;
    logic [ACC_BITS-1:0]   push_bound;
    logic                  push_last;

    // Queue-to-back transfer.
    logic                  pop;
    logic                  q_empty;
    logic [ENTRY_BITS-1:0] q_rdata;
    logic [ACC_BITS-1:0]   distance;

    // Unpack the coordinate fields; the first point's coordinates sit lowest.
    always_comb begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
            first[i]  = i_s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            second[i] = i_s_axis_tdata[(GROUP_SIZE+i)*COORD_BITS +: COORD_BITS];
        end
    end
    assign bound = i_s_axis_tdata[BOUND_LSB +: ACC_BITS];

    gl1sd_front #(
        .COORD_BITS (COORD_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_first  (first),
        .i_second (second),
        .i_bound  (bound),
        .i_last   (i_s_axis_tlast),
        .i_pop    (pop),
        .o_push   (push),
        .o_sq     (push_sq),
        .o_bound  (push_bound),
        .o_last   (push_last)
    );

    // Queue entry layout from bit 0: squared group sum, bound, last flag.
    gl1sd_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({push_last, push_bound, push_sq}),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    gl1sd_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_sq         (q_rdata[ACC_BITS-1:0]),
        .i_bound      (q_rdata[2*ACC_BITS-1:ACC_BITS]),
        .i_last       (q_rdata[2*ACC_BITS]),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_distance   (distance),
        .o_over_bound (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = OUT_DATA_BITS'(distance);

endmodule

`default_nettype wire
